// ----- src/ute_pkg.sv -----
// ----------------------------------------------------------------------------
// ute_pkg
// Shared widths, constants, types and constant-divide helpers for the UTC
// date and time to Unix epoch converter.
// ----------------------------------------------------------------------------
package ute_pkg;

  localparam int DATE_W  = 19;
  localparam int TIME_W  = 18;
  localparam int EPOCH_W = 32;
  localparam int DAY_W   = 6;
  localparam int FIELD_W = 7;
  localparam int HOUR_W  = 5;
  localparam int SOD_W   = 17;
  localparam int Q100_W  = 13;
  localparam int DOY_W   = 12;
  localparam int MONTHS  = 2 ** FIELD_W;

  localparam int RECIP_10000_W = 19;
  localparam int RECIP_100_W   = 20;
  localparam int SHIFT_10000   = 32;
  localparam int SHIFT_100     = 26;
  localparam int PROD_10000_W  = DATE_W + RECIP_10000_W;
  localparam int PROD_100_W    = DATE_W + RECIP_100_W;

  localparam logic [RECIP_10000_W-1:0] RECIP_10000 = RECIP_10000_W'(429497);
  localparam logic [RECIP_100_W-1:0]   RECIP_100   = RECIP_100_W'(671089);

  localparam logic [DATE_W-1:0]  DEC_BASE        = DATE_W'(100);
  localparam logic [FIELD_W-1:0] LAST_WINTER_MON = FIELD_W'(2);
  localparam logic [EPOCH_W-1:0] DAYS_PER_YEAR   = EPOCH_W'(365);
  localparam logic [EPOCH_W-1:0] DAYS_MAR_2000   = EPOCH_W'(11017);
  localparam logic [EPOCH_W-1:0] DAYS_MAR_1999   = EPOCH_W'(10651);
  localparam logic [EPOCH_W-1:0] SECONDS_PER_DAY = EPOCH_W'(86400);
  localparam logic [SOD_W-1:0]   SECS_PER_HOUR   = SOD_W'(3600);
  localparam logic [SOD_W-1:0]   SECS_PER_MIN    = SOD_W'(60);

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] yy;
  } civil_date_t;

  typedef struct packed {
    logic [HOUR_W-1:0]  hours;
    logic [FIELD_W-1:0] minutes;
    logic [FIELD_W-1:0] seconds;
  } clock_time_t;

  typedef logic [DOY_W-1:0] month_table_t [MONTHS];

  // Exact for every 19-bit operand: the reciprocal error times the operand
  // stays below two to the power of the shift.
  function automatic logic [DAY_W-1:0] div_10000(input logic [DATE_W-1:0] x);
    logic [PROD_10000_W-1:0] prod;
    prod = PROD_10000_W'(x) * PROD_10000_W'(RECIP_10000);
    return prod[SHIFT_10000 +: DAY_W];
  endfunction

  function automatic logic [Q100_W-1:0] div_100(input logic [DATE_W-1:0] x);
    logic [PROD_100_W-1:0] prod;
    prod = PROD_100_W'(x) * PROD_100_W'(RECIP_100);
    return prod[SHIFT_100 +: Q100_W];
  endfunction

  // Days from the start of the March-based year to the first of each month,
  // indexed by the calendar month code, including codes past December.
  function automatic month_table_t build_month_table();
    month_table_t tab;
    int cum [MONTHS];
    int q;
    int r;
    int moff;
    q = 0;
    r = 2;
    for (int m = 0; m < MONTHS; m++) begin
      cum[m] = q;
      q = q + 30;
      r = r + 3;
      if (r >= 5) begin
        r = r - 5;
        q = q + 1;
      end
    end
    for (int mo = 0; mo < MONTHS; mo++) begin
      moff = (mo > 2) ? (mo - 3) : (mo + 9);
      tab[mo] = DOY_W'(cum[moff]);
    end
    return tab;
  endfunction

  localparam month_table_t MONTH_START = build_month_table();

endpackage

// ----- src/ute_in_if.sv -----
// ----------------------------------------------------------------------------
// ute_in_if
// Input channel: packed DDMMYY date and HHMMSS time with valid/ready.
// ----------------------------------------------------------------------------
interface ute_in_if import ute_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATE_W-1:0] packed_date;
  logic [TIME_W-1:0] packed_time;

  modport source (output valid, output packed_date, output packed_time, input ready);
  modport sink   (input valid, input packed_date, input packed_time, output ready);
endinterface

// ----- src/ute_out_if.sv -----
// ----------------------------------------------------------------------------
// ute_out_if
// Result channel: Unix epoch seconds with valid/ready.
// ----------------------------------------------------------------------------
interface ute_out_if import ute_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ----- src/utc_date_time_to_epoch.sv -----
// Three register stages (decimal split, day count and seconds of day, final
// multiply by 86400 and add) lie between an input transfer and its result.
// Throughput: one item per cycle while the output channel is ready.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage loads whenever it is empty or the stage after it moves.
// ----------------------------------------------------------------------------
// utc_date_time_to_epoch
// Converts a DDMMYY date and HHMMSS time into 32-bit Unix epoch seconds.
// ----------------------------------------------------------------------------
module utc_date_time_to_epoch import ute_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ute_in_if.sink       in_chan,
  ute_out_if.source    out_chan
);

  logic               s1_valid_r, s2_valid_r, s3_valid_r;
  logic               s1_load, s2_load, s3_load;

  civil_date_t        s1_date_r, s1_date_nxt;
  clock_time_t        s1_time_r, s1_time_nxt;
  logic [EPOCH_W-1:0] s2_days_r, s2_days_nxt;
  logic [SOD_W-1:0]   s2_sod_r, s2_sod_nxt;
  logic [EPOCH_W-1:0] s3_epoch_r, s3_epoch_nxt;

  logic [DAY_W-1:0]   date_q10000, time_q10000;
  logic [Q100_W-1:0]  date_q100, time_q100;
  logic [DATE_W-1:0]  time_ext;

  assign s3_load       = !s3_valid_r || out_chan.ready;
  assign s2_load       = !s2_valid_r || s3_load;
  assign s1_load       = !s1_valid_r || s2_load;
  assign in_chan.ready = s1_load;

  always_comb begin
    time_ext    = DATE_W'(in_chan.packed_time);
    date_q10000 = div_10000(in_chan.packed_date);
    date_q100   = div_100(in_chan.packed_date);
    time_q10000 = div_10000(time_ext);
    time_q100   = div_100(time_ext);

    s1_date_nxt.day   = date_q10000;
    s1_date_nxt.month = FIELD_W'(date_q100 - Q100_W'(date_q10000) * Q100_W'(DEC_BASE));
    s1_date_nxt.yy    = FIELD_W'(in_chan.packed_date - DATE_W'(date_q100) * DEC_BASE);

    s1_time_nxt.hours   = HOUR_W'(time_q10000);
    s1_time_nxt.minutes = FIELD_W'(time_q100 - Q100_W'(time_q10000) * Q100_W'(DEC_BASE));
    s1_time_nxt.seconds = FIELD_W'(time_ext - DATE_W'(time_q100) * DEC_BASE);
  end

  ute_day_count u_day_count (
    .date_i (s1_date_r),
    .days_o (s2_days_nxt)
  );

  always_comb begin
    s2_sod_nxt   = SOD_W'(s1_time_r.hours) * SECS_PER_HOUR
                 + SOD_W'(s1_time_r.minutes) * SECS_PER_MIN
                 + SOD_W'(s1_time_r.seconds);
    s3_epoch_nxt = s2_days_r * SECONDS_PER_DAY + EPOCH_W'(s2_sod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_load) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_date_r <= s1_date_nxt;
      s1_time_r <= s1_time_nxt;
    end
    if (s2_load) begin
      s2_days_r <= s2_days_nxt;
      s2_sod_r  <= s2_sod_nxt;
    end
    if (s3_load) begin
      s3_epoch_r <= s3_epoch_nxt;
    end
  end

  assign out_chan.valid         = s3_valid_r;
  assign out_chan.epoch_seconds = s3_epoch_r;

endmodule

// ----- src/ute_day_count.sv -----
// ----------------------------------------------------------------------------
// ute_day_count
// Civil date to days since 1970-01-01 for years 2000 to 2099, using a
// March-based year so that February ends the year.
// ----------------------------------------------------------------------------
module ute_day_count import ute_pkg::*; (
  input  civil_date_t        date_i,
  output logic [EPOCH_W-1:0] days_o
);

  logic               borrow;
  logic [FIELD_W-1:0] yoe;
  logic [EPOCH_W-1:0] doy;
  logic [EPOCH_W-1:0] year_days;

  always_comb begin
    borrow = (date_i.month <= LAST_WINTER_MON);
    yoe    = date_i.yy - FIELD_W'(borrow);
    doy    = EPOCH_W'(MONTH_START[date_i.month]) + EPOCH_W'(date_i.day) - EPOCH_W'(1);
    // January and February of 2000 belong to the March-based year 1999.
    if (borrow && (date_i.yy == '0)) begin
      year_days = DAYS_MAR_1999;
    end else begin
      year_days = DAYS_MAR_2000 + EPOCH_W'(yoe) * DAYS_PER_YEAR
                + EPOCH_W'(yoe[FIELD_W-1:2]);
    end
    days_o = year_days + doy;
  end

endmodule
